[sv/dcoa_pkg.sv]
`default_nettype none

package dcoa_pkg;

    // Field widths.
    localparam int DIST_W  = 10;
    localparam int SPEED_W = 7;
    localparam int CMD_W   = 8;
    localparam int MASK_W  = 8;
    localparam int CLOSE_W = 4;
    localparam int SPIN_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Speed limits and counter ceilings.
    localparam logic [SPEED_W-1:0] START_SPEED = SPEED_W'(70);
    localparam logic [SPEED_W-1:0] SPEED_TOP   = SPEED_W'(100);
    localparam logic [CLOSE_W-1:0] CLOSE_TOP   = CLOSE_W'(15);

    // Command characters.
    localparam logic [CMD_W-1:0] CMD_NONE    = 8'h00;
    localparam logic [CMD_W-1:0] CMD_SPD_DN  = 8'h30;  // '0'
    localparam logic [CMD_W-1:0] CMD_BACK    = 8'h31;  // '1'
    localparam logic [CMD_W-1:0] CMD_STOP    = 8'h32;  // '2'
    localparam logic [CMD_W-1:0] CMD_FWD     = 8'h33;  // '3'
    localparam logic [CMD_W-1:0] CMD_SPIN_L  = 8'h35;  // '5'
    localparam logic [CMD_W-1:0] CMD_SPIN_R  = 8'h36;  // '6'
    localparam logic [CMD_W-1:0] CMD_LEFT    = 8'h37;  // '7'
    localparam logic [CMD_W-1:0] CMD_RIGHT   = 8'h38;  // '8'
    localparam logic [CMD_W-1:0] CMD_SPD_UP  = 8'h39;  // '9'

    // Motor pin patterns.
    localparam logic [MASK_W-1:0] MASK_STOP  = 8'h00;
    localparam logic [MASK_W-1:0] MASK_RIGHT = 8'h44;
    localparam logic [MASK_W-1:0] MASK_FWD   = 8'h66;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE     = 3'd0,
        CFG_MIN      = 3'd1,
        CFG_MAX      = 3'd2,
        CFG_DEBOUNCE = 3'd3,
        CFG_SPIN     = 3'd4,
        CFG_STEP     = 3'd5
    } t_cfg_idx;

    // Configuration register set.
    typedef struct packed {
        logic [7:0]         base;
        logic [7:0]         th_min;
        logic [7:0]         th_max;
        logic [CLOSE_W-1:0] debounce;
        logic [SPIN_W-1:0]  spin_limit;
        logic [SPEED_W-1:0] step;
    } t_cfg;

    // Direction pattern for a motion command.
    function automatic logic [MASK_W-1:0] mask_for(input logic [CMD_W-1:0] cmd);
        logic [MASK_W-1:0] m;
        case (cmd)
            CMD_BACK:   m = 8'h99;
            CMD_FWD:    m = MASK_FWD;
            CMD_SPIN_L: m = 8'hAA;
            CMD_SPIN_R: m = 8'h55;
            CMD_LEFT:   m = 8'h22;
            CMD_RIGHT:  m = MASK_RIGHT;
            default:    m = MASK_STOP;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[sv/drive_command_obstacle_avoider_top.sv]
`default_nettype none

// Channel   Direction  Signals                                  Handshake
// input     in         i_in_valid, o_in_stall, i_kind,          valid & !stall
//                      i_command_byte, i_distance_cm
// result    out        o_out_valid, i_out_stall, o_direction_mask, valid & !stall
//                      o_speed_percent, o_active_command, o_avoiding,
//                      o_obstacle_alarm, o_stuck
// config    in         i_cfg_valid, o_cfg_ready, i_cfg_index,   valid & ready
//                      i_cfg_data
//
// The state update is one pass of compare and saturate logic, and the
// result appears the cycle after acceptance.
// One item is accepted per cycle while the result side is not stalled.
// Reset is synchronous; the result register is empty after reset.
// A stalled result holds the input stall high; the next item enters on the
// edge at which the waiting result is taken.

module drive_command_obstacle_avoider_top
    import dcoa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_kind,
    input  wire logic [CMD_W-1:0]      i_command_byte,
    input  wire logic [DIST_W-1:0]     i_distance_cm,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [MASK_W-1:0]          o_direction_mask,
    output logic [SPEED_W-1:0]         o_speed_percent,
    output logic [CMD_W-1:0]           o_active_command,
    output logic                       o_avoiding,
    output logic                       o_obstacle_alarm,
    output logic                       o_stuck,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg w_cfg;

    logic [CMD_W-1:0]   r_cmd,    n_cmd;
    logic [SPEED_W-1:0] r_speed,  n_speed;
    logic [DIST_W-1:0]  r_cached, n_cached;
    logic [CLOSE_W-1:0] r_close,  n_close;
    logic               r_avoid,  n_avoid;
    logic [SPIN_W-1:0]  r_spin,   n_spin;
    logic [MASK_W-1:0]  r_mask,   n_mask;
    logic               r_alarm,  n_alarm;
    logic               r_stuck,  n_stuck;
    logic               r_out_valid;

    logic               w_accept;
    logic [8:0]         w_th_sum;
    logic [8:0]         w_th_lo;
    logic [8:0]         w_th;
    logic [DIST_W-1:0]  w_cached_new;
    logic               w_raw_close;
    logic               w_cached_close;
    logic [CLOSE_W-1:0] w_close_inc;
    logic [SPEED_W:0]   w_speed_up;
    logic               w_watch_mode;

    dcoa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Handshake: a new transaction enters unless a result is held up.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Speed-dependent threshold, raised to the minimum, then capped.
    assign w_th_sum = {1'b0, w_cfg.base} + 9'(r_speed[SPEED_W-1:1]);
    assign w_th_lo  = (w_th_sum < {1'b0, w_cfg.th_min}) ? {1'b0, w_cfg.th_min} : w_th_sum;
    assign w_th     = (w_th_lo > {1'b0, w_cfg.th_max}) ? {1'b0, w_cfg.th_max} : w_th_lo;

    // Closeness of the raw sample and of the refreshed cache.
    assign w_cached_new   = (i_distance_cm != '0) ? i_distance_cm : r_cached;
    assign w_raw_close    = (i_distance_cm != '0) && (i_distance_cm < DIST_W'(w_th));
    assign w_cached_close = (w_cached_new != '0) && (w_cached_new < DIST_W'(w_th));
    assign w_close_inc    = (r_close < CLOSE_TOP) ? r_close + 1'b1 : r_close;
    assign w_speed_up     = {1'b0, r_speed} + {1'b0, w_cfg.step};
    assign w_watch_mode   = (r_cmd == CMD_FWD) || (r_cmd == CMD_SPIN_L) || (r_cmd == CMD_SPIN_R);

    // Next state for one accepted transaction.
    always_comb begin
        n_cmd    = r_cmd;
        n_speed  = r_speed;
        n_cached = r_cached;
        n_close  = r_close;
        n_avoid  = r_avoid;
        n_spin   = r_spin;
        n_mask   = r_mask;
        n_alarm  = r_alarm;
        n_stuck  = r_stuck;
        if (w_accept) begin
            n_alarm = 1'b0;
            n_stuck = 1'b0;
            if (!i_kind) begin
                // Command byte; ignored during avoidance or when zero.
                if (!r_avoid && i_command_byte != CMD_NONE) begin
                    if (i_command_byte == CMD_SPD_UP) begin
                        n_speed = (w_speed_up > {1'b0, SPEED_TOP}) ? SPEED_TOP
                                                                   : w_speed_up[SPEED_W-1:0];
                    end else if (i_command_byte == CMD_SPD_DN) begin
                        n_speed = (r_speed > w_cfg.step) ? r_speed - w_cfg.step : '0;
                    end else begin
                        n_cmd   = i_command_byte;
                        n_close = '0;
                        n_mask  = mask_for(i_command_byte);
                    end
                end
            end else if (r_avoid) begin
                // Poll while spinning right.
                if (!w_raw_close) begin
                    n_avoid = 1'b0;
                    n_cmd   = CMD_FWD;
                    n_mask  = MASK_FWD;
                    n_close = '0;
                end else if (r_spin < w_cfg.spin_limit) begin
                    n_spin = r_spin + 1'b1;
                end else begin
                    n_avoid = 1'b0;
                    n_cmd   = CMD_STOP;
                    n_mask  = MASK_STOP;
                    n_close = '0;
                    n_stuck = 1'b1;
                end
            end else begin
                // Sample while driving: debounce the close condition.
                n_cached = w_cached_new;
                if (w_watch_mode) begin
                    if (w_cached_close) begin
                        n_close = w_close_inc;
                        if (w_close_inc >= w_cfg.debounce) begin
                            n_alarm = 1'b1;
                            n_avoid = 1'b1;
                            n_spin  = '0;
                            n_close = '0;
                            n_mask  = MASK_RIGHT;
                        end
                    end else begin
                        n_close = '0;
                    end
                end
            end
        end
    end

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= CMD_NONE;
            r_speed     <= START_SPEED;
            r_cached    <= '1;
            r_close     <= '0;
            r_avoid     <= 1'b0;
            r_spin      <= '0;
            r_mask      <= MASK_STOP;
            r_alarm     <= 1'b0;
            r_stuck     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmd    <= n_cmd;
            r_speed  <= n_speed;
            r_cached <= n_cached;
            r_close  <= n_close;
            r_avoid  <= n_avoid;
            r_spin   <= n_spin;
            r_mask   <= n_mask;
            r_alarm  <= n_alarm;
            r_stuck  <= n_stuck;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The state registers hold the result while it waits.
    assign o_out_valid      = r_out_valid;
    assign o_direction_mask = r_mask;
    assign o_speed_percent  = r_speed;
    assign o_active_command = r_cmd;
    assign o_avoiding       = r_avoid;
    assign o_obstacle_alarm = r_alarm;
    assign o_stuck          = r_stuck;

`ifndef NO_ASSERTIONS
    // While avoiding, the motors always turn right.
    a_avoid_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_avoid |-> (r_mask == MASK_RIGHT))
        else $error("avoid mode without right-turn mask");

    // The alarm only accompanies the start of avoidance.
    a_alarm_avoid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alarm |-> (r_avoid && r_spin == '0 && r_close == '0))
        else $error("alarm without fresh avoid mode");

    // Giving up leaves the block stopped.
    a_stuck_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stuck |-> (!r_avoid && r_cmd == CMD_STOP && r_mask == MASK_STOP))
        else $error("stuck flag without stop");

    // Speed stays saturated.
    a_speed_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_speed <= SPEED_TOP)
        else $error("speed above ceiling");

    // A held result keeps the state frozen.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> ($stable(r_cmd) && $stable(r_speed) && $stable(r_avoid)))
        else $error("state changed under a stalled result");
`endif

endmodule

`default_nettype wire

[sv/dcoa_cfg.sv]
`default_nettype none

module dcoa_cfg
    import dcoa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    // Writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file; writes to unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base       <= 8'd30;
            r_cfg.th_min     <= 8'd60;
            r_cfg.th_max     <= 8'd85;
            r_cfg.debounce   <= CLOSE_W'(2);
            r_cfg.spin_limit <= SPIN_W'(150);
            r_cfg.step       <= SPEED_W'(10);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BASE:     r_cfg.base       <= i_cfg_data[7:0];
                CFG_MIN:      r_cfg.th_min     <= i_cfg_data[7:0];
                CFG_MAX:      r_cfg.th_max     <= i_cfg_data[7:0];
                CFG_DEBOUNCE: r_cfg.debounce   <= i_cfg_data[CLOSE_W-1:0];
                CFG_SPIN:     r_cfg.spin_limit <= i_cfg_data[SPIN_W-1:0];
                CFG_STEP:     r_cfg.step       <= i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[test/tb_drive_command_obstacle_avoider_top.sv]
`timescale 1ns / 1ps

module tb_drive_command_obstacle_avoider_top
    import dcoa_pkg::*;
();

    // One drive status word, as the block reports it after each item.
    typedef struct packed {
        logic [MASK_W-1:0]  mask;
        logic [SPEED_W-1:0] speed;
        logic [CMD_W-1:0]   cmd;
        logic               avoiding;
        logic               alarm;
        logic               stuck;
    } t_drive_status;

    // A row of the opening sequence is either an item or a register write.
    typedef enum logic {ROW_ITEM, ROW_REG} t_row_op;

    typedef struct packed {
        t_row_op            op;
        logic               kind;
        logic [CMD_W-1:0]   cmd;
        logic [DIST_W-1:0]  dist_cm;
        t_cfg_idx           reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic               known;
        t_drive_status      want;
    } t_plan_row;

    localparam t_drive_status NO_WANT = '0;

    // Clock, reset and block inputs, all known from time zero.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_kind = 1'b0;
    logic [CMD_W-1:0] i_command_byte = '0;
    logic [DIST_W-1:0] i_distance_cm = '0;
    logic i_out_stall = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic o_in_stall;
    logic o_out_valid;
    logic [MASK_W-1:0] o_direction_mask;
    logic [SPEED_W-1:0] o_speed_percent;
    logic [CMD_W-1:0] o_active_command;
    logic o_avoiding;
    logic o_obstacle_alarm;
    logic o_stuck;
    logic o_cfg_ready;

    // Shadow copy of the controller state and its registers.
    logic [CMD_W-1:0]   sh_cmd;
    logic [SPEED_W-1:0] sh_speed;
    logic [DIST_W-1:0]  sh_cached;
    logic [CLOSE_W-1:0] sh_close;
    logic               sh_avoid;
    logic [SPIN_W-1:0]  sh_spin;
    logic [MASK_W-1:0]  sh_mask;
    t_cfg               sh_regs;

    t_drive_status drive_forecast[$];
    int mismatch_count = 0;
    int status_index = 0;
    int live_items = 0;
    bit idle_on = 1'b0;
    int stall_left = 0;

    // Opening sequence: reset state, speed steps and saturation, every motion
    // command, debounce into avoidance, ignored commands, blocked and clear
    // polls, a zero echo during avoidance, and giving up at the spin limit.
    t_plan_row opening_plan [27] = '{
        '{ROW_ITEM, 1'b0, CMD_NONE, 10'd0, CFG_BASE, 10'd0, 1'b1,
          '{MASK_STOP, 7'd70, CMD_NONE, 1'b0, 1'b0, 1'b0}},
        '{ROW_ITEM, 1'b0, CMD_SPD_UP, 10'd0, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b0, CMD_SPD_UP, 10'd0, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b0, CMD_SPD_UP, 10'd0, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b0, CMD_SPD_UP, 10'd0, CFG_BASE, 10'd0, 1'b1,
          '{MASK_STOP, 7'd100, CMD_NONE, 1'b0, 1'b0, 1'b0}},
        '{ROW_ITEM, 1'b0, CMD_SPD_DN, 10'd0, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b0, CMD_BACK, 10'd0, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b0, CMD_LEFT, 10'd0, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b0, CMD_RIGHT, 10'd0, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b0, CMD_SPIN_R, 10'd0, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b0, CMD_SPIN_L, 10'd0, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b0, 8'hFF, 10'd1023, CFG_BASE, 10'd0, 1'b1,
          '{MASK_STOP, 7'd90, 8'hFF, 1'b0, 1'b0, 1'b0}},
        '{ROW_ITEM, 1'b0, CMD_FWD, 10'd0, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b1, CMD_NONE, 10'd1023, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b1, CMD_NONE, 10'd10, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b1, 8'hFF, 10'd0, CFG_BASE, 10'd0, 1'b1,
          '{MASK_RIGHT, 7'd90, CMD_FWD, 1'b1, 1'b1, 1'b0}},
        '{ROW_ITEM, 1'b0, CMD_SPD_UP, 10'd0, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b1, CMD_NONE, 10'd74, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b1, CMD_NONE, 10'd75, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b1, CMD_NONE, 10'd0, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b1, CMD_NONE, 10'd0, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b1, CMD_NONE, 10'd0, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_REG, 1'b0, CMD_NONE, 10'd0, CFG_SPIN, 10'd1, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b1, CMD_NONE, 10'd0, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b1, CMD_NONE, 10'd0, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b1, CMD_NONE, 10'd5, CFG_BASE, 10'd0, 1'b0, NO_WANT},
        '{ROW_ITEM, 1'b1, CMD_NONE, 10'd5, CFG_BASE, 10'd0, 1'b1,
          '{MASK_STOP, 7'd90, CMD_STOP, 1'b0, 1'b0, 1'b1}}
    };

    drive_command_obstacle_avoider_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_command_byte   (i_command_byte),
        .i_distance_cm    (i_distance_cm),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_direction_mask (o_direction_mask),
        .o_speed_percent  (o_speed_percent),
        .o_active_command (o_active_command),
        .o_avoiding       (o_avoiding),
        .o_obstacle_alarm (o_obstacle_alarm),
        .o_stuck          (o_stuck),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Motor pin pattern for each motion command.
    function automatic logic [MASK_W-1:0] pin_pattern(input logic [CMD_W-1:0] cmd);
        case (cmd)
            CMD_BACK:   return 8'h99;
            CMD_FWD:    return 8'h66;
            CMD_SPIN_L: return 8'hAA;
            CMD_SPIN_R: return 8'h55;
            CMD_LEFT:   return 8'h22;
            CMD_RIGHT:  return 8'h44;
            default:    return 8'h00;
        endcase
    endfunction

    // Obstacle threshold in cm at the current speed.
    function automatic int obstacle_threshold();
        int th;
        th = int'(sh_regs.base) + int'(sh_speed) / 2;
        if (th < int'(sh_regs.th_min)) th = int'(sh_regs.th_min);
        if (th > int'(sh_regs.th_max)) th = int'(sh_regs.th_max);
        return th;
    endfunction

    function automatic bit is_near(input logic [DIST_W-1:0] d);
        return (d != '0) && (int'(d) < obstacle_threshold());
    endfunction

    // State and register values right after reset.
    function automatic void reset_controller();
        sh_regs.base = 8'd30;
        sh_regs.th_min = 8'd60;
        sh_regs.th_max = 8'd85;
        sh_regs.debounce = 4'd2;
        sh_regs.spin_limit = 10'd150;
        sh_regs.step = 7'd10;
        sh_cmd = CMD_NONE;
        sh_speed = START_SPEED;
        sh_cached = '1;
        sh_close = '0;
        sh_avoid = 1'b0;
        sh_spin = '0;
        sh_mask = MASK_STOP;
    endfunction

    // Advance the shadow controller by one item and return its status word.
    function automatic t_drive_status advance_controller(input logic kind,
                                                         input logic [CMD_W-1:0] cmd,
                                                         input logic [DIST_W-1:0] dist_cm);
        t_drive_status st;
        int s;
        st = '0;
        if (!kind) begin
            if (!sh_avoid && cmd != CMD_NONE) begin
                if (cmd == CMD_SPD_UP) begin
                    s = int'(sh_speed) + int'(sh_regs.step);
                    sh_speed = (s > int'(SPEED_TOP)) ? SPEED_TOP : SPEED_W'(s);
                end else if (cmd == CMD_SPD_DN) begin
                    sh_speed = (sh_speed > sh_regs.step) ? sh_speed - sh_regs.step : '0;
                end else begin
                    sh_cmd = cmd;
                    sh_close = '0;
                    sh_mask = pin_pattern(cmd);
                end
            end
        end else if (sh_avoid) begin
            // Each sample during avoidance polls the raw distance.
            if (!is_near(dist_cm)) begin
                sh_avoid = 1'b0;
                sh_cmd = CMD_FWD;
                sh_mask = pin_pattern(CMD_FWD);
                sh_close = '0;
            end else if (sh_spin < sh_regs.spin_limit) begin
                sh_spin = sh_spin + 1'b1;
            end else begin
                sh_avoid = 1'b0;
                sh_cmd = CMD_STOP;
                sh_mask = MASK_STOP;
                sh_close = '0;
                st.stuck = 1'b1;
            end
        end else begin
            if (dist_cm != '0) sh_cached = dist_cm;
            if (sh_cmd == CMD_FWD || sh_cmd == CMD_SPIN_L || sh_cmd == CMD_SPIN_R) begin
                if (is_near(sh_cached)) begin
                    if (sh_close != CLOSE_TOP) sh_close = sh_close + 1'b1;
                    if (sh_close >= sh_regs.debounce) begin
                        st.alarm = 1'b1;
                        sh_avoid = 1'b1;
                        sh_spin = '0;
                        sh_close = '0;
                        sh_mask = pin_pattern(CMD_RIGHT);
                    end
                end else begin
                    sh_close = '0;
                end
            end
        end
        st.mask = sh_mask;
        st.speed = sh_speed;
        st.cmd = sh_cmd;
        st.avoiding = sh_avoid;
        return st;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at status %0d: %s", status_index, msg);
        mismatch_count++;
    endtask

    // Random idle gap on the sending side.
    function automatic int idle_gap();
        if (idle_on && $urandom_range(0, 99) < 20) return $urandom_range(1, 5);
        return 0;
    endfunction

    // Offer one item and wait for its transaction; valid stays high afterwards
    // so that back-to-back items need no second assignment in one step.
    task automatic send_item(input logic kind, input logic [CMD_W-1:0] cmd,
                             input logic [DIST_W-1:0] dist_cm, input logic known,
                             input t_drive_status want);
        t_drive_status st;
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_command_byte <= cmd;
        i_distance_cm <= dist_cm;
        do @(posedge i_clk); while (o_in_stall);
        if (!(kind == 1'b0 && (cmd == CMD_NONE || sh_avoid))) live_items++;
        st = advance_controller(kind, cmd, dist_cm);
        drive_forecast.push_back(known ? want : st);
    endtask

    // Stop sending and let every outstanding status word arrive.
    task automatic drain_forecast();
        i_in_valid <= 1'b0;
        while (drive_forecast.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // One register write transaction; the caller lowers valid afterwards.
    task automatic write_reg(input t_cfg_idx idx, input int value);
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'(value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BASE:     sh_regs.base = v[7:0];
            CFG_MIN:      sh_regs.th_min = v[7:0];
            CFG_MAX:      sh_regs.th_max = v[7:0];
            CFG_DEBOUNCE: sh_regs.debounce = v[CLOSE_W-1:0];
            CFG_SPIN:     sh_regs.spin_limit = v[SPIN_W-1:0];
            CFG_STEP:     sh_regs.step = v[SPEED_W-1:0];
            default:      ;
        endcase
    endtask

    task automatic load_settings(input int base, input int th_min, input int th_max,
                                 input int debounce, input int spin, input int step);
        drain_forecast();
        write_reg(CFG_BASE, base);
        write_reg(CFG_MIN, th_min);
        write_reg(CFG_MAX, th_max);
        write_reg(CFG_DEBOUNCE, debounce);
        write_reg(CFG_SPIN, spin);
        write_reg(CFG_STEP, step);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CMD_W-1:0] pick_command();
        case ($urandom_range(0, 11))
            0:       return CMD_NONE;
            1:       return CMD_SPD_DN;
            2:       return CMD_BACK;
            3:       return CMD_STOP;
            4:       return CMD_FWD;
            5:       return CMD_SPIN_L;
            6:       return CMD_SPIN_R;
            7:       return CMD_LEFT;
            8:       return CMD_RIGHT;
            9:       return CMD_SPD_UP;
            default: return CMD_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Distance sample biased toward the current threshold.
    function automatic logic [DIST_W-1:0] pick_distance(input int near_pct);
        int th;
        int r;
        th = obstacle_threshold();
        r = $urandom_range(0, 99);
        if (r < 6) return '0;
        if (r < near_pct && th > 1) return DIST_W'($urandom_range(1, th - 1));
        if (r % 4 == 0) return DIST_W'(th);
        return DIST_W'($urandom_range(th, 1023));
    endfunction

    // Mostly a motion command followed by a run of samples, else noise.
    task automatic run_episode();
        int n;
        int near_pct;
        logic [CMD_W-1:0] cmd;
        if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: cmd = CMD_FWD;
                4, 5:       cmd = CMD_SPIN_L;
                6:          cmd = CMD_SPIN_R;
                7:          cmd = CMD_SPD_UP;
                8:          cmd = CMD_SPD_DN;
                default:    cmd = pick_command();
            endcase
            send_item(1'b0, cmd, DIST_W'($urandom_range(0, 1023)), 1'b0, NO_WANT);
            near_pct = $urandom_range(40, 100);
            n = $urandom_range(1, 40);
            repeat (n) begin
                send_item(1'b1, CMD_W'($urandom_range(0, 255)), pick_distance(near_pct),
                          1'b0, NO_WANT);
            end
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                cmd = $urandom_range(0, 1) ? pick_command() : CMD_W'($urandom_range(0, 255));
                send_item(1'($urandom_range(0, 1)), cmd, DIST_W'($urandom_range(0, 1023)),
                          1'b0, NO_WANT);
            end
        end
    endtask

    // Stall bursts on the result side.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 99) < 20) begin
            stall_left <= $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each accepted status transaction with the oldest forecast.
    always @(posedge i_clk) begin
        t_drive_status want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drive_forecast.size() == 0) begin
                flag_mismatch("status word with nothing outstanding");
            end else begin
                want = drive_forecast.pop_front();
                if (o_direction_mask !== want.mask)
                    flag_mismatch($sformatf("direction_mask %h, want %h",
                                            o_direction_mask, want.mask));
                if (o_speed_percent !== want.speed)
                    flag_mismatch($sformatf("speed_percent %0d, want %0d",
                                            o_speed_percent, want.speed));
                if (o_active_command !== want.cmd)
                    flag_mismatch($sformatf("active_command %h, want %h",
                                            o_active_command, want.cmd));
                if (o_avoiding !== want.avoiding)
                    flag_mismatch($sformatf("avoiding %b, want %b", o_avoiding, want.avoiding));
                if (o_obstacle_alarm !== want.alarm)
                    flag_mismatch($sformatf("obstacle_alarm %b, want %b",
                                            o_obstacle_alarm, want.alarm));
                if (o_stuck !== want.stuck)
                    flag_mismatch($sformatf("stuck %b, want %b", o_stuck, want.stuck));
            end
            status_index++;
        end
    end

    // Main sequence: reset, opening rows, then random phases.
    initial begin
        int phase;
        int quota;
        reset_controller();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        foreach (opening_plan[r]) begin
            if (opening_plan[r].op == ROW_REG) begin
                drain_forecast();
                write_reg(opening_plan[r].reg_idx, int'(opening_plan[r].reg_val));
                i_cfg_valid <= 1'b0;
            end else begin
                send_item(opening_plan[r].kind, opening_plan[r].cmd, opening_plan[r].dist_cm,
                          opening_plan[r].known, opening_plan[r].want);
            end
        end

        // Each phase starts from an idle block with new register values.
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       load_settings(0, 0, 255, 1, 1, 100);
                1:       load_settings(255, 255, 255, 15, 1023, 1);
                2:       load_settings(40, 90, 50, 3, 5, 7);
                3:       load_settings(30, 60, 85, 2, 150, 10);
                default: load_settings($urandom_range(0, 120), $urandom_range(0, 200),
                                       $urandom_range(0, 255), $urandom_range(1, 4),
                                       $urandom_range(1, 12), $urandom_range(1, 100));
            endcase
            idle_on = (phase != 4) && (phase != 7);
            quota = live_items + 245;
            while (live_items < quota) run_episode();
        end

        drain_forecast();
        if (mismatch_count == 0) begin
            $display("tb_drive_command_obstacle_avoider_top: PASS");
        end else begin
            $display("tb_drive_command_obstacle_avoider_top: FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5000000;
        $display("tb_drive_command_obstacle_avoider_top: FAIL");
        $finish;
    end

endmodule
